// ----- hw/rtl/bseg_pkg.sv -----
// Shared types and constants for the buzzer sound effect generator.
`default_nettype none

package bseg_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_UNITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_UNITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd2;

    localparam logic [3:0]  HIGH_UNITS_RST   = 4'd1;
    localparam logic [7:0]  LOW_UNITS_RST    = 8'd29;
    localparam logic [15:0] TICKS_PER_MS_RST = 16'd1000;

    typedef struct packed {
        logic              op;
        logic [7:0]        period;
        logic [7:0]        length;
        logic [7:0]        repeats;
        logic [7:0]        pause_ms;
        logic signed [7:0] deviation;
    } t_item;

    typedef struct packed {
        logic [3:0]  high_units;
        logic [7:0]  low_units;
        logic [15:0] ticks_per_ms;
    } t_cfg;

    typedef struct packed {
        logic buzzer;
        logic busy_res;
        logic done_res;
        logic rejected;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/buzzer_sound_effect_generator_top.sv -----
// Top level of the buzzer sound effect generator: handshakes, registers and engine.
//
// Each input transfer is either a one-microsecond tick (op 0) or a start command
// (op 1) with period, length, repeats, pause and deviation. Every input transfer
// yields exactly one output transfer with the buzzer level, busy, done and
// rejected flags, in order.
// An accepted item is held in an input register and then processed into the output
// register, which shows its result; while the output stalls it waits in the input register.
// One item is accepted in every cycle unless the input side stalls; the effect state updates once per item.
// When the receiver stalls, the output register holds its result and the input
// register fills; the input side stalls only while both are occupied and the
// output is still stalled.
// Configuration writes go to the high units, low units and ticks per millisecond
// registers and are to be made only while the block is idle; the block does not enforce this.
// Synchronous reset empties both registers, stops any effect and restores the
// configuration defaults.
`default_nettype none

module buzzer_sound_effect_generator_top #(
    parameter int unsigned LENGTH_SHIFT = 7
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bseg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bseg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_op,
    input  wire logic [7:0]                          i_period,
    input  wire logic [7:0]                          i_length,
    input  wire logic [7:0]                          i_repeats,
    input  wire logic [7:0]                          i_pause_ms,
    input  wire logic signed [7:0]                   i_deviation,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_buzzer,
    output logic                                     o_busy_res,
    output logic                                     o_done_res,
    output logic                                     o_rejected
);
    import bseg_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;
    t_result eng_res;
    logic    adv;
    logic    accept;

    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_units   <= HIGH_UNITS_RST;
            r_cfg.low_units    <= LOW_UNITS_RST;
            r_cfg.ticks_per_ms <= TICKS_PER_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HIGH_UNITS:   r_cfg.high_units   <= i_cfg_data[3:0];
                CFG_LOW_UNITS:    r_cfg.low_units    <= i_cfg_data[7:0];
                CFG_TICKS_PER_MS: r_cfg.ticks_per_ms <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_item.op        <= i_op;
            r_s1_item.period    <= i_period;
            r_s1_item.length    <= i_length;
            r_s1_item.repeats   <= i_repeats;
            r_s1_item.pause_ms  <= i_pause_ms;
            r_s1_item.deviation <= i_deviation;
        end
    end

    bseg_engine #(
        .LENGTH_SHIFT (LENGTH_SHIFT)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_buzzer    = r_out.buzzer;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_rejected  = r_out.rejected;

endmodule

`default_nettype wire

// ----- hw/rtl/bseg_engine.sv -----
// Effect state and per-item next-state logic of the buzzer sound effect generator.
`default_nettype none

module bseg_engine #(
    parameter int unsigned LENGTH_SHIFT = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire bseg_pkg::t_item  i_item,
    input  wire bseg_pkg::t_cfg   i_cfg,
    output bseg_pkg::t_result     o_res
);
    import bseg_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_PAUSE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [15:0]        r_inner, n_inner;
    logic [7:0]         r_outer, n_outer;
    logic signed [15:0] r_budget, n_budget;
    logic [7:0]         r_period, n_period;
    logic [7:0]         r_repeats, n_repeats;
    logic [7:0]         r_length, n_length;
    logic [7:0]         r_pause, n_pause;
    logic signed [7:0]  r_dev, n_dev;
    logic [15:0]        r_tpm, n_tpm;

    logic [7:0]         low_eff;
    logic [15:0]        reload;
    logic signed [9:0]  dev_diff;
    logic [7:0]         fin_period;
    logic [7:0]         fin_repeats;
    logic signed [15:0] budget_next;
    logic               do_finish;
    logic               do_repeat;
    logic               do_pulse;
    logic [7:0]         pulse_period;
    logic [7:0]         repeat_length;
    t_result            res;

    always_comb begin
        low_eff  = (i_cfg.low_units == 8'd0) ? 8'd1 : i_cfg.low_units;
        reload   = (r_phase == PH_PAUSE) ? r_tpm : {8'd0, r_period};
        dev_diff = $signed({2'b00, r_period}) - $signed({{2{r_dev[7]}}, r_dev});
        if (r_dev[7]) begin
            fin_period = (dev_diff > 10'sd255) ? 8'd255 : dev_diff[7:0];
        end else if (r_period > r_dev[7:0]) begin
            fin_period = dev_diff[7:0];
        end else begin
            fin_period = r_period;
        end
        fin_repeats = r_repeats - 8'd1;
        budget_next = r_budget - $signed({8'd0, r_period});

        n_phase   = r_phase;
        n_inner   = r_inner;
        n_outer   = r_outer;
        n_budget  = r_budget;
        n_period  = r_period;
        n_repeats = r_repeats;
        n_length  = r_length;
        n_pause   = r_pause;
        n_dev     = r_dev;
        n_tpm     = r_tpm;
        res       = '0;
        do_finish = 1'b0;
        do_repeat = 1'b0;
        do_pulse  = 1'b0;
        pulse_period  = r_period;
        repeat_length = r_length;

        if (i_item.op == OP_START) begin
            if (r_phase != PH_IDLE || i_item.period == 8'd0) begin
                res.rejected = 1'b1;
            end else begin
                n_period  = i_item.period;
                n_length  = i_item.length;
                n_repeats = i_item.repeats;
                n_pause   = i_item.pause_ms;
                n_dev     = i_item.deviation;
                if (i_item.repeats == 8'd0) begin
                    res.done_res = 1'b1;
                end else begin
                    do_repeat     = 1'b1;
                    repeat_length = i_item.length;
                    pulse_period  = i_item.period;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            res.buzzer = (r_phase == PH_HIGH);
            if (r_inner != 16'd1) begin
                n_inner = r_inner - 16'd1;
            end else if (r_outer != 8'd1) begin
                n_inner = reload;
                n_outer = r_outer - 8'd1;
            end else begin
                case (r_phase)
                    PH_HIGH: begin
                        n_phase = PH_LOW;
                        n_inner = {8'd0, r_period};
                        n_outer = low_eff;
                    end
                    PH_LOW: begin
                        n_budget = budget_next;
                        if (!budget_next[15]) begin
                            do_pulse = 1'b1;
                        end else if (r_pause != 8'd0 && i_cfg.ticks_per_ms != 16'd0) begin
                            n_phase = PH_PAUSE;
                            n_inner = i_cfg.ticks_per_ms;
                            n_outer = r_pause;
                            n_tpm   = i_cfg.ticks_per_ms;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                    default: begin
                        do_finish = 1'b1;
                    end
                endcase
            end
        end

        if (do_finish) begin
            n_period  = fin_period;
            n_repeats = fin_repeats;
            if (fin_repeats != 8'd0) begin
                do_repeat    = 1'b1;
                pulse_period = fin_period;
            end else begin
                n_phase      = PH_IDLE;
                res.done_res = 1'b1;
            end
        end

        if (do_repeat) begin
            n_budget = $signed(16'({8'd0, repeat_length} << LENGTH_SHIFT));
            do_pulse = 1'b1;
        end

        if (do_pulse) begin
            n_inner = {8'd0, pulse_period};
            if (i_cfg.high_units != 4'd0) begin
                n_phase = PH_HIGH;
                n_outer = {4'd0, i_cfg.high_units};
            end else begin
                n_phase = PH_LOW;
                n_outer = low_eff;
            end
        end

        if (i_item.op == OP_START) begin
            res.buzzer = (n_phase == PH_HIGH);
        end
        res.busy_res = (n_phase != PH_IDLE);
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_inner   <= '0;
            r_outer   <= '0;
            r_budget  <= '0;
            r_period  <= '0;
            r_repeats <= '0;
            r_length  <= '0;
            r_pause   <= '0;
            r_dev     <= '0;
            r_tpm     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_inner   <= n_inner;
            r_outer   <= n_outer;
            r_budget  <= n_budget;
            r_period  <= n_period;
            r_repeats <= n_repeats;
            r_length  <= n_length;
            r_pause   <= n_pause;
            r_dev     <= n_dev;
            r_tpm     <= n_tpm;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bseg_checker.sv -----
// Port-level assertions for the buzzer sound effect generator and their binding.
`default_nettype none

module bseg_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_buzzer,
    input wire logic              o_busy_res,
    input wire logic              o_done_res,
    input wire logic              o_rejected
);

    a_done_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_rejected))
        else $error("Done and rejected reported in the same transfer.");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_buzzer)
        else $error("Buzzer high in the transfer that ends an effect.");

    a_high_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_buzzer) |-> o_busy_res)
        else $error("Buzzer high while the block reports idle.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_buzzer) && $stable(o_busy_res)
             && $stable(o_done_res) && $stable(o_rejected)))
        else $error("Stalled output transfer changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

endmodule

bind buzzer_sound_effect_generator_top bseg_checker u_bseg_checker (.*);

`default_nettype wire
